@@ src/ikht_pkg.sv @@
// ----------------------------------------------------------------------------
// ikht_pkg
// Shared types and constants for the keyed handle table.
// ----------------------------------------------------------------------------
package ikht_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int HANDLE_SPAN_DEF = 32768;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 31;
  localparam int STATUS_W = 3;
  localparam int SLOTO_W  = 4;
  localparam int SEQ_W    = 16;
  localparam int CFG_W    = 5;

  // tdata layouts, padded to whole bytes
  localparam int S_DATA_W = 72;  // key, create, exclusive, handle
  localparam int M_DATA_W = 40;  // handle, slot

  localparam logic [CFG_W-1:0] CFG_SLOTS_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOENT     = 3'd1,
    ST_EXIST     = 3'd2,
    ST_FULL      = 3'd3,
    ST_BADHANDLE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_GET_END,
    S_HREAD,
    S_HCHECK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_read;
    logic get_end;
    logic hcheck;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/ipc_key_handle_table_top.sv @@
// ----------------------------------------------------------------------------
// ipc_key_handle_table_top
// Keyed handle table for message queues: get by key, handle lookup, remove.
//
//   channel  dir  transaction contents
//   s_axis   in   tuser operation; tdata key, create, exclusive, handle
//   m_axis   out  tuser status; tdata handle, slot index
//   cfg      in   slots_in_use, written when cfg_we_i is high
//
// A get scans the searched slots through the key RAM one per cycle. Lookup
// and remove do one RAM read and check. One transaction is in work at a
// time; the next is accepted while the previous result waits in the output
// register. Reset clears the valid bits and the sequence counter and sets
// the size to sixteen.
// ----------------------------------------------------------------------------
module ipc_key_handle_table_top #(
  parameter int TABLE_SLOTS = ikht_pkg::TABLE_SLOTS_DEF,
  parameter int HANDLE_SPAN = ikht_pkg::HANDLE_SPAN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ikht_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // lookup_key[31:0], create_flag[32], exclusive_flag[33], handle_in[64:34]
  input  logic [ikht_pkg::S_DATA_W-1:0] s_axis_tdata,
  // operation[1:0]
  input  logic [ikht_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // handle_out[30:0], slot_index[34:31]
  output logic [ikht_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [ikht_pkg::STATUS_W-1:0] m_axis_tuser
);

  import ikht_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ikht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ikht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .HANDLE_SPAN (HANDLE_SPAN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

@@ src/ikht_ram.sv @@
// ----------------------------------------------------------------------------
// ikht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ikht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ikht_ctrl.sv @@
// ----------------------------------------------------------------------------
// ikht_ctrl
// Sequencer for the handle table: accept, key scan or handle check, result.
// ----------------------------------------------------------------------------
module ikht_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  ikht_pkg::dp_stat_t   stat_i,
  output ikht_pkg::ctrl_cmd_t  cmd_o
);

  import ikht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = stat_i.is_get ? S_SCAN : S_HREAD;
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_GET_END;
        end
      end
      S_GET_END: state_d = S_OUT;
      S_HREAD:   state_d = S_HCHECK;
      S_HCHECK:  state_d = S_OUT;
      S_OUT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o       = 1'b1;
        cmd_o.load_item  = s_tvalid_i;
        cmd_o.scan_start = s_tvalid_i;
      end
      S_SCAN: begin
        cmd_o.scan_read = !stat_i.scan_done;
      end
      S_GET_END: cmd_o.get_end = 1'b1;
      S_HCHECK:  cmd_o.hcheck  = 1'b1;
      S_OUT: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ src/ikht_dp.sv @@
// ----------------------------------------------------------------------------
// ikht_dp
// Datapath: item and size registers, valid bits, key and sequence RAM,
// scan compare, allocation, handle decode and the result and output registers.
// ----------------------------------------------------------------------------
module ikht_dp #(
  parameter int TABLE_SLOTS = ikht_pkg::TABLE_SLOTS_DEF,
  parameter int HANDLE_SPAN = ikht_pkg::HANDLE_SPAN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ikht_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [ikht_pkg::S_DATA_W-1:0]  s_tdata_i,
  input  logic [ikht_pkg::OP_W-1:0]      s_tuser_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [ikht_pkg::M_DATA_W-1:0]  m_tdata_o,
  output logic [ikht_pkg::STATUS_W-1:0]  m_tuser_o,
  input  ikht_pkg::ctrl_cmd_t            cmd_i,
  output ikht_pkg::dp_stat_t             stat_o
);

  import ikht_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int SPAN_W = $clog2(HANDLE_SPAN);
  localparam int RAM_W  = KEY_W + SEQ_W;

  function automatic logic [HANDLE_W-1:0] make_handle(input logic [SLOT_W-1:0] slot,
                                                      input logic [SEQ_W-1:0]  seq);
    logic [HANDLE_W-1:0] h;
    h = HANDLE_W'(32'(seq) << SPAN_W) | HANDLE_W'(slot);
    return h;
  endfunction

  // item
  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    key_q;
  logic                create_q;
  logic                excl_q;
  logic [HANDLE_W-1:0] handle_q;

  logic [CFG_W-1:0]       cfg_q;
  logic [TABLE_SLOTS-1:0] valid_q;
  logic [SEQ_W-1:0]       next_seq_q;

  // scan
  logic [CNT_W-1:0]  idx_q;
  logic [SLOT_W-1:0] rd_slot_q;
  logic              rd_vld_q;
  logic              match_q;
  logic [SLOT_W-1:0] match_slot_q;
  logic [SEQ_W-1:0]  match_seq_q;
  logic              free_q;
  logic [SLOT_W-1:0] free_slot_q;

  // result
  status_e             res_status_q;
  logic [HANDLE_W-1:0] res_handle_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [SLOT_W-1:0]   out_slot_q;

  logic [CNT_W-1:0]  size;
  logic [SLOT_W-1:0] idx_slot;
  logic [SPAN_W-1:0] h_slot_full;
  logic [SLOT_W-1:0] h_slot;
  logic              h_in_range;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [SEQ_W-1:0]  rd_seq;

  logic              scan_hit;
  logic              free_hit;

  status_e             g_status;
  logic [HANDLE_W-1:0] g_handle;
  logic [SLOT_W-1:0]   g_slot;
  logic                g_alloc;

  status_e             h_status;
  logic [HANDLE_W-1:0] h_handle;
  logic [SLOT_W-1:0]   h_slot_res;
  logic                h_remove;

  always_comb begin
    if (32'(cfg_q) > 32'(TABLE_SLOTS)) begin
      size = CNT_W'(TABLE_SLOTS);
    end else begin
      size = CNT_W'(cfg_q);
    end
  end

  assign idx_slot    = idx_q[SLOT_W-1:0];
  assign h_slot_full = handle_q[SPAN_W-1:0];
  assign h_slot      = h_slot_full[SLOT_W-1:0];
  assign h_in_range  = 32'(h_slot_full) < 32'(size);

  assign rd_key = ram_rdata[KEY_W-1:0];
  assign rd_seq = ram_rdata[RAM_W-1:KEY_W];

  assign scan_hit = rd_vld_q && valid_q[rd_slot_q] && (rd_key == key_q) &&
                    (key_q != '0) && !match_q;
  assign free_hit = cmd_i.scan_read && !valid_q[idx_slot] && !free_q;

  // get decision
  always_comb begin
    g_status = ST_NOENT;
    g_handle = '0;
    g_slot   = '0;
    g_alloc  = 1'b0;
    if (match_q) begin
      if (excl_q) begin
        g_status = ST_EXIST;
      end else begin
        g_status = ST_OK;
        g_handle = make_handle(match_slot_q, match_seq_q);
        g_slot   = match_slot_q;
      end
    end else if ((key_q == '0) || create_q) begin
      if (free_q) begin
        g_status = ST_OK;
        g_handle = make_handle(free_slot_q, next_seq_q);
        g_slot   = free_slot_q;
        g_alloc  = 1'b1;
      end else begin
        g_status = ST_FULL;
      end
    end
  end

  // handle check
  always_comb begin
    h_status   = ST_BADHANDLE;
    h_handle   = '0;
    h_slot_res = '0;
    h_remove   = 1'b0;
    if (((op_q == OP_LOOKUP) || (op_q == OP_REMOVE)) && h_in_range &&
        valid_q[h_slot] &&
        (32'(handle_q >> SPAN_W) == 32'(rd_seq))) begin
      h_status   = ST_OK;
      h_handle   = handle_q;
      h_slot_res = h_slot;
      h_remove   = (op_q == OP_REMOVE);
    end
  end

  assign ram_we    = cmd_i.get_end && g_alloc;
  assign ram_wdata = {next_seq_q, key_q};
  assign ram_raddr = cmd_i.scan_read ? idx_slot : h_slot;

  ikht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_SLOTS_RESET;
      valid_q     <= '0;
      next_seq_q  <= '0;
      rd_vld_q    <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      rd_vld_q <= cmd_i.scan_read;
      if (cmd_i.scan_start) begin
        idx_q   <= '0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_read) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (scan_hit) begin
          match_q <= 1'b1;
        end
        if (free_hit) begin
          free_q <= 1'b1;
        end
      end
      if (ram_we) begin
        valid_q[free_slot_q] <= 1'b1;
        next_seq_q           <= next_seq_q + SEQ_W'(1);
      end
      if (cmd_i.hcheck && h_remove) begin
        valid_q[h_slot] <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= s_tuser_i;
      key_q    <= s_tdata_i[31:0];
      create_q <= s_tdata_i[32];
      excl_q   <= s_tdata_i[33];
      handle_q <= s_tdata_i[64:34];
    end
    rd_slot_q <= idx_slot;
    if (scan_hit) begin
      match_slot_q <= rd_slot_q;
      match_seq_q  <= rd_seq;
    end
    if (free_hit) begin
      free_slot_q <= idx_slot;
    end
    if (cmd_i.get_end) begin
      res_status_q <= g_status;
      res_handle_q <= g_handle;
      res_slot_q   <= g_slot;
    end else if (cmd_i.hcheck) begin
      res_status_q <= h_status;
      res_handle_q <= h_handle;
      res_slot_q   <= h_slot_res;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign stat_o.is_get    = (op_q == OP_GET);
  assign stat_o.scan_done = (idx_q == size);
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = {5'b0, SLOTO_W'(out_slot_q), out_handle_q};

endmodule

@@ bench/ipc_key_handle_table_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipc_key_handle_table_top_test
// Self-checking bench for the keyed handle table. A queue-fed driver sends
// get, lookup, remove and unused-op transactions in random bursts. A local
// table model predicts every reply, and the monitor compares status,
// handle and slot. The run goes through several table sizes: zero, one,
// a shrunk table, the full sixteen and values above it. Handles and keys
// are often taken from live entries when the transaction is driven, so
// that lookups and removes hit.
// ----------------------------------------------------------------------------
module ipc_key_handle_table_top_test;
  import ikht_pkg::*;

  localparam int SLOT_BITS = $clog2(HANDLE_SPAN_DEF);
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_CYCLES = 32;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic                create;
    logic                excl;
    logic [HANDLE_W-1:0] handle;
    logic                live_handle;
    logic                live_key;
    logic                mangle;
  } table_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOTO_W-1:0]  slot;
  } table_reply_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i = CFG_SLOTS_RESET;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]     s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  // table model
  logic             tbl_valid [TABLE_SLOTS_DEF];
  logic [KEY_W-1:0] tbl_key   [TABLE_SLOTS_DEF];
  logic [SEQ_W-1:0] tbl_seq   [TABLE_SLOTS_DEF];
  logic [SEQ_W-1:0] seq_next;
  logic [CFG_W-1:0] slots_cfg;

  table_req_t   pending_reqs[$];
  table_reply_t expected_replies[$];
  table_req_t   bus_req;
  int           burst_left = 0;
  int           gap_left = 0;
  int           mismatch_cnt = 0;
  int           idle_cycles = 0;
  int           hold_left = 0;
  int           replies_taken = 0;
  logic         long_hold_done = 1'b0;
  logic [15:0]  rx_cycle = '0;

  ipc_key_handle_table_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int search_limit();
    return (slots_cfg > TABLE_SLOTS_DEF) ? TABLE_SLOTS_DEF : int'(slots_cfg);
  endfunction

  function automatic table_reply_t alloc_slot(logic [KEY_W-1:0] key);
    table_reply_t rep;
    rep = '{status: ST_FULL, handle: '0, slot: '0};
    for (int i = 0; i < search_limit(); i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_key[i] = key;
        tbl_seq[i] = seq_next;
        rep = '{status: ST_OK, handle: {seq_next, SLOT_BITS'(i)}, slot: SLOTO_W'(i)};
        seq_next = seq_next + 1'b1;
        return rep;
      end
    end
    return rep;
  endfunction

  function automatic table_reply_t handle_table_step(table_req_t r);
    table_reply_t     rep;
    int               slot;
    logic [SEQ_W-1:0] hseq;
    rep = '{status: ST_BADHANDLE, handle: '0, slot: '0};
    if (r.op == OP_GET) begin
      if (r.key == '0) return alloc_slot(r.key);
      for (int i = 0; i < search_limit(); i++) begin
        if (tbl_valid[i] && tbl_key[i] == r.key) begin
          if (r.excl) begin
            rep.status = ST_EXIST;
          end else begin
            rep = '{status: ST_OK, handle: {tbl_seq[i], SLOT_BITS'(i)}, slot: SLOTO_W'(i)};
          end
          return rep;
        end
      end
      if (r.create) return alloc_slot(r.key);
      rep.status = ST_NOENT;
    end else if (r.op == OP_LOOKUP || r.op == OP_REMOVE) begin
      slot = int'(r.handle[SLOT_BITS-1:0]);
      hseq = r.handle[HANDLE_W-1:SLOT_BITS];
      if (slot < search_limit() && tbl_valid[slot] && tbl_seq[slot] == hseq) begin
        if (r.op == OP_REMOVE) tbl_valid[slot] = 1'b0;
        rep = '{status: ST_OK, handle: r.handle, slot: SLOTO_W'(slot)};
      end
    end
    return rep;
  endfunction

  function automatic table_req_t rand_req();
    table_req_t r;
    int         pick;
    r = '{op: OP_GET, key: $urandom(), create: 1'($urandom_range(0, 1)),
          excl: ($urandom_range(0, 3) == 0), handle: HANDLE_W'($urandom()),
          live_handle: 1'b0, live_key: 1'b0, mangle: 1'b0};
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      case ($urandom_range(0, 5))
        0: r.key = '0;
        1, 2: r.key = KEY_W'($urandom_range(1, 6));
        3: r.live_key = 1'b1;
        4: r.key = {1'b1, 31'($urandom_range(0, 3))};
        default: ;
      endcase
      r.create = ($urandom_range(0, 9) < 7);
    end else if (pick < 95) begin
      r.op = (pick < 72) ? OP_LOOKUP : OP_REMOVE;
      r.live_handle = ($urandom_range(0, 4) != 0);
      r.mangle = ($urandom_range(0, 9) == 0);
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  function automatic void add_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                  logic create, logic excl,
                                  logic [HANDLE_W-1:0] handle, logic live = 1'b0);
    pending_reqs.push_back('{op: op, key: key, create: create, excl: excl, handle: handle,
                             live_handle: live, live_key: 1'b0, mangle: 1'b0});
  endfunction

  // request driver: bursts of random length, random gaps
  always @(posedge clk_i or negedge rst_ni) begin : req_drive
    int live_slots[$];
    int pick;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(handle_table_step(bus_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          bus_req = pending_reqs.pop_front();
          live_slots.delete();
          for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
            if (tbl_valid[i]) live_slots.push_back(i);
          end
          if (live_slots.size() > 0) begin
            pick = live_slots[$urandom_range(0, live_slots.size() - 1)];
            if (bus_req.live_handle) begin
              bus_req.handle = {tbl_seq[pick], SLOT_BITS'(pick)};
              if (bus_req.mangle) begin
                bus_req.handle = bus_req.handle ^
                                 (HANDLE_W'(1) << $urandom_range(0, HANDLE_W - 1));
              end
            end
            if (bus_req.live_key) bus_req.key = tbl_key[pick];
          end
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= bus_req.op;
          s_axis_tdata <= S_DATA_W'({bus_req.handle, bus_req.excl, bus_req.create,
                                     bus_req.key});
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
    end
  end

  // reply ready pattern, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin : reply_ready
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) replies_taken++;
      rx_cycle = rx_cycle + 1'b1;
      if (!long_hold_done && replies_taken >= 80) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0: m_axis_tready <= 1'b1;
          2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
          2'd2: m_axis_tready <= (rx_cycle[1:0] == 2'd0);
          default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : reply_check
    table_reply_t want;
    table_reply_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tuser, handle: m_axis_tdata[HANDLE_W-1:0],
              slot: m_axis_tdata[HANDLE_W +: SLOTO_W]};
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected transaction: status=%0d handle=%h slot=%0d",
                 $time, got.status, got.handle, got.slot);
        mismatch_cnt++;
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status || got.handle !== want.handle ||
            got.slot !== want.slot) begin
          $display("%0t: mismatch: expected status=%0d handle=%h slot=%0d, actual status=%0d handle=%h slot=%0d",
                   $time, want.status, want.handle, want.slot,
                   got.status, got.handle, got.slot);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_table_size(logic [CFG_W-1:0] value);
    wait_quiet();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    slots_cfg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(logic [CFG_W-1:0] size, int count);
    set_table_size(size);
    repeat (count) pending_reqs.push_back(rand_req());
  endtask

  initial begin : stimulus
    for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_seq[i] = '0;
    end
    seq_next = '0;
    slots_cfg = CFG_SLOTS_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // three slots: empty table, allocation, exists, full
    set_table_size(5'd3);
    add_req(OP_LOOKUP, '0, 1'b0, 1'b0, '0);
    add_req(OP_REMOVE, '0, 1'b0, 1'b0, '1);
    add_req(OP_GET, 32'd5, 1'b0, 1'b0, '0);
    add_req(OP_GET, '0, 1'b0, 1'b0, '0);
    add_req(OP_GET, 32'd5, 1'b1, 1'b0, '0);
    add_req(OP_GET, 32'd5, 1'b1, 1'b1, '0);
    add_req(OP_GET, 32'd5, 1'b0, 1'b0, '0);
    add_req(OP_GET, 32'h8000_0000, 1'b1, 1'b1, '0);
    add_req(OP_GET, 32'h7FFF_FFFF, 1'b1, 1'b0, '0);
    add_req(OP_GET, '0, 1'b1, 1'b1, '0);
    add_req(OP_LOOKUP, '0, 1'b0, 1'b0, {16'd1, 15'd1});
    add_req(OP_LOOKUP, '0, 1'b0, 1'b0, {16'd2, 15'd1});
    add_req(OP_LOOKUP, '0, 1'b0, 1'b0, '0, 1'b1);
    add_req(OP_REMOVE, '0, 1'b0, 1'b0, {16'd1, 15'd1});
    add_req(OP_REMOVE, '0, 1'b0, 1'b0, {16'd1, 15'd1});
    add_req(OP_LOOKUP, '0, 1'b0, 1'b0, '1);
    add_req(OP_UNUSED, '1, 1'b1, 1'b1, '1);
    add_req(OP_GET, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    add_req(OP_GET, 32'd5, 1'b0, 1'b0, '0);

    // shrunk table hides upper slots
    set_table_size(5'd1);
    add_req(OP_GET, 32'h8000_0000, 1'b0, 1'b0, '0);
    add_req(OP_LOOKUP, '0, 1'b0, 1'b0, {16'd2, 15'd2});
    add_req(OP_LOOKUP, '0, 1'b0, 1'b0, '0);
    add_req(OP_GET, 32'h8000_0000, 1'b1, 1'b0, '0);

    // no slot searched
    set_table_size(5'd0);
    add_req(OP_GET, '0, 1'b0, 1'b0, '0);
    add_req(OP_GET, 32'd7, 1'b0, 1'b0, '0);
    add_req(OP_GET, 32'd7, 1'b1, 1'b0, '0);
    add_req(OP_REMOVE, '0, 1'b0, 1'b0, '0);

    run_random(5'd31, 150);
    run_random(CFG_W'($urandom_range(2, 15)), 100);
    run_random(5'd16, 100);
    run_random(5'd1, 50);
    run_random(5'd17, 50);

    wait_quiet();
    if (mismatch_cnt == 0 && expected_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
